// ----- src/lezic_pkg.sv -----
// Shared types, constants and a lookup function for the lidar ellipse zone intrusion counter.
package lezic_pkg;

    localparam int MAX_SAMPLES = 2048;
    localparam int COUNT_W = 12;
    localparam int COUNT_HW_MAX = 4095;
    localparam int COUNT_CAP = (MAX_SAMPLES < COUNT_HW_MAX) ? MAX_SAMPLES : COUNT_HW_MAX;

    localparam int ANGLE_W = 16;
    localparam int RANGE_W = 16;
    localparam int RADIUS_W = 12;
    localparam int OFFSET_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CORDIC_ITERS = 14;
    localparam int ITER_W = $clog2(CORDIC_ITERS);
    localparam int CS_W = 18;
    localparam int CORDIC_GAIN_INV = 19898;
    localparam int ATAN_W = 14;

    localparam int MUL_W = 30;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIST_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 3'd0,
        REG_ANGLE_STEP = 3'd1,
        REG_RADIUS_X   = 3'd2,
        REG_RADIUS_Y   = 3'd3,
        REG_OFFSET_X   = 3'd4,
        REG_OFFSET_Y   = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_DX,
        ST_SQ_DX,
        ST_MUL_DY,
        ST_SQ_DY,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [ANGLE_W-1:0]     angle;
    } cordic_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [CS_W-1:0] cos_val;
        logic signed [CS_W-1:0] sin_val;
    } cordic_res_t;

    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                4'd0:    v = 14'd8192;
                4'd1:    v = 14'd4836;
                4'd2:    v = 14'd2555;
                4'd3:    v = 14'd1297;
                4'd4:    v = 14'd651;
                4'd5:    v = 14'd326;
                4'd6:    v = 14'd163;
                4'd7:    v = 14'd81;
                4'd8:    v = 14'd41;
                4'd9:    v = 14'd20;
                4'd10:   v = 14'd10;
                4'd11:   v = 14'd5;
                4'd12:   v = 14'd3;
                4'd13:   v = 14'd1;
                default: v = 14'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- src/lidar_ellipse_zone_intrusion_count_unit.sv -----
// Top level of the lidar ellipse zone intrusion counter: sequencer, registers and datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  s_axis    | tvalid / tready        | tdata range_mm, tuser no_return, tlast last_of_scan
//  m_axis    | tvalid / tready        | tdata stop, intrusion_count (one beat per scan)
//  cfg       | cfg_we                 | cfg_index, cfg_data
//
// A sample with a return runs 14 CORDIC rotations while the shared multiplier forms rx*ry
// and its square; then come the x and y products, dx*ry, dy*rx and their squares, and the
// decide and emit states. A sample with no return goes straight to decide and emit. The last
// sample of a scan waits in the emit state until the output register is free. Reset restores
// the register defaults, the half-turn angle and a zero count at once; no clearing pass is needed.
module lidar_ellipse_zone_intrusion_count_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,  // [15:0] range_mm
    input  logic                                  s_axis_tuser,  // [0] no_return
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [15:0]                           m_axis_tdata,  // [0] stop, [12:1] count
    input  logic                                  cfg_we,
    input  logic [lezic_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lezic_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lezic_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]  thr_reg;
    logic [ANGLE_W-1:0]  step_reg;
    logic [RADIUS_W-1:0] rx_reg;
    logic [RADIUS_W-1:0] ry_reg;
    logic [OFFSET_W-1:0] offx_reg;
    logic [OFFSET_W-1:0] offy_reg;

    logic [ANGLE_W-1:0]  acc_reg, acc_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [RANGE_W-1:0]  range_reg;
    logic                nr_reg;
    logic                last_reg;
    logic [1:0]          rr_phase_reg, rr_phase_next;
    logic [DIST_W-1:0]   dx_reg, dy_reg;
    logic [PROD_W-1:0]   lhs_reg;
    logic [2*2*RADIUS_W-1:0] rhs_reg;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_stop_reg, out_stop_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic                     accept;
    logic                     out_free;
    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    cordic_req_t              creq;
    cordic_res_t              cres;

    logic signed [CS_W:0]     coord;
    logic signed [CS_W:0]     diff;
    logic [DIST_W-1:0]        dist_abs;
    logic [PROD_W:0]          lhs_sum;
    logic [COUNT_W-1:0]       cnt_inc;
    logic signed [MUL_W-1:0]  sq_op;

    lezic_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .res   (cres)
    );

    lezic_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_cnt_reg, out_stop_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_axis_tuser ? ST_DECIDE : ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cres.done)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_MUL_DX;
            ST_MUL_DX: state_next = ST_SQ_DX;
            ST_SQ_DX:  state_next = ST_MUL_DY;
            ST_MUL_DY: state_next = ST_SQ_DY;
            ST_SQ_DY:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // The coordinate is the product rounded to whole millimetres, then offset and folded to a magnitude.
    always_comb
    begin
        coord = $signed({prod[CS_W+15-1], prod[CS_W+15-1:15]})
              + $signed({{CS_W{1'b0}}, prod[14]});
        diff  = coord - $signed({{(CS_W+1-OFFSET_W){offy_reg[OFFSET_W-1]}}, offy_reg});
        if (state_reg == ST_MUL_Y)
        begin
            diff = coord - $signed({{(CS_W+1-OFFSET_W){offx_reg[OFFSET_W-1]}}, offx_reg});
        end
        dist_abs = diff[CS_W] ? DIST_W'(-diff) : DIST_W'(diff);
        lhs_sum  = {1'b0, lhs_reg} + {1'b0, prod};
        cnt_inc  = (cnt_reg < COUNT_W'(COUNT_CAP)) ? cnt_reg + 1'b1 : cnt_reg;
        sq_op    = $signed({1'b0, prod[MUL_W-2:0]});
    end

    always_comb
    begin
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        creq.start     = 1'b0;
        creq.angle     = acc_reg;
        rr_phase_next  = rr_phase_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_stop_next  = out_stop_reg;
        out_cnt_next   = out_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rr_phase_next = 2'd0;
                creq.start    = accept && !s_axis_tuser;
            end
            ST_CORDIC:
            begin
                if (rr_phase_reg != 2'd3)
                begin
                    rr_phase_next = rr_phase_reg + 1'b1;
                end
                if (rr_phase_reg == 2'd0)
                begin
                    mul_en = 1'b1;
                    mul_a  = $signed({{(MUL_W-RADIUS_W){1'b0}}, rx_reg});
                    mul_b  = $signed({{(MUL_W-RADIUS_W){1'b0}}, ry_reg});
                end
                else if (rr_phase_reg == 2'd1)
                begin
                    mul_en = 1'b1;
                    mul_a  = sq_op;
                    mul_b  = sq_op;
                end
            end
            ST_MUL_X:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_W-RANGE_W){1'b0}}, range_reg});
                mul_b  = MUL_W'(cres.cos_val);
            end
            ST_MUL_Y:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_W-RANGE_W){1'b0}}, range_reg});
                mul_b  = MUL_W'(cres.sin_val);
            end
            ST_MUL_DX:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_W-DIST_W){1'b0}}, dx_reg});
                mul_b  = $signed({{(MUL_W-RADIUS_W){1'b0}}, ry_reg});
            end
            ST_MUL_DY:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_W-DIST_W){1'b0}}, dy_reg});
                mul_b  = $signed({{(MUL_W-RADIUS_W){1'b0}}, rx_reg});
            end
            ST_SQ_DX, ST_SQ_DY:
            begin
                mul_en = 1'b1;
                mul_a  = sq_op;
                mul_b  = sq_op;
            end
            ST_DECIDE:
            begin
                hit_next = !nr_reg && (lhs_sum <= {{(PROD_W+1-2*2*RADIUS_W){1'b0}}, rhs_reg});
            end
            ST_EMIT:
            begin
                if (!last_reg)
                begin
                    acc_next = acc_reg - step_reg;
                    cnt_next = hit_reg ? cnt_inc : cnt_reg;
                end
                else if (out_free)
                begin
                    acc_next       = {1'b1, {(ANGLE_W-1){1'b0}}};
                    cnt_next       = '0;
                    out_valid_next = 1'b1;
                    out_cnt_next   = hit_reg ? cnt_inc : cnt_reg;
                    out_stop_next  = (hit_reg ? cnt_inc : cnt_reg) > thr_reg;
                end
            end
            default:
            begin
                rr_phase_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= COUNT_W'(10);
            step_reg      <= ANGLE_W'(182);
            rx_reg        <= RADIUS_W'(270);
            ry_reg        <= RADIUS_W'(170);
            offx_reg      <= OFFSET_W'(100);
            offy_reg      <= '0;
            acc_reg       <= {1'b1, {(ANGLE_W-1){1'b0}}};
            cnt_reg       <= '0;
            rr_phase_reg  <= 2'd0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            rr_phase_reg  <= rr_phase_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  thr_reg  <= cfg_data[COUNT_W-1:0];
                    REG_ANGLE_STEP: step_reg <= cfg_data[ANGLE_W-1:0];
                    REG_RADIUS_X:   rx_reg   <= cfg_data[RADIUS_W-1:0];
                    REG_RADIUS_Y:   ry_reg   <= cfg_data[RADIUS_W-1:0];
                    REG_OFFSET_X:   offx_reg <= cfg_data[OFFSET_W-1:0];
                    REG_OFFSET_Y:   offy_reg <= cfg_data[OFFSET_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_stop_reg <= out_stop_next;
        out_cnt_reg  <= out_cnt_next;
        if (accept)
        begin
            range_reg <= s_axis_tdata[RANGE_W-1:0];
            nr_reg    <= s_axis_tuser;
            last_reg  <= s_axis_tlast;
        end
        if (state_reg == ST_CORDIC && rr_phase_reg == 2'd2)
        begin
            rhs_reg <= prod[2*2*RADIUS_W-1:0];
        end
        if (state_reg == ST_MUL_Y)
        begin
            dx_reg <= dist_abs;
        end
        if (state_reg == ST_MUL_DX)
        begin
            dy_reg <= dist_abs;
        end
        if (state_reg == ST_MUL_DY)
        begin
            lhs_reg <= prod;
        end
    end

endmodule

// ----- src/lezic_mul.sv -----
// Shared signed multiplier with a registered product.
module lezic_mul (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [lezic_pkg::MUL_W-1:0]  a,
    input  logic signed [lezic_pkg::MUL_W-1:0]  b,
    output logic signed [lezic_pkg::PROD_W-1:0] prod
);
    import lezic_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- src/lezic_cordic.sv -----
// Iterative CORDIC that turns a binary angle into Q15 cosine and sine, one rotation per cycle.
module lezic_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lezic_pkg::cordic_req_t req,
    output lezic_pkg::cordic_res_t res
);
    import lezic_pkg::*;

    logic signed [CS_W-1:0] x_reg, x_next;
    logic signed [CS_W-1:0] y_reg, y_next;
    logic signed [CS_W-1:0] z_reg, z_next;
    logic signed [CS_W-1:0] cos_reg;
    logic signed [CS_W-1:0] sin_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic                   busy_reg;
    logic                   neg_reg;
    logic                   done_reg;

    logic signed [ANGLE_W:0] ang_ext;
    logic signed [ANGLE_W:0] ang_fold;
    logic                    fold_neg;
    logic signed [CS_W-1:0]  xs;
    logic signed [CS_W-1:0]  ys;
    logic signed [CS_W-1:0]  atan_val;
    logic                    last_iter;

    // Fold the angle into the right half plane; the result of a folded angle is negated afterwards.
    always_comb
    begin
        ang_ext = $signed({req.angle[ANGLE_W-1], req.angle});
        ang_fold = ang_ext;
        fold_neg = 1'b0;
        if (ang_ext > 17'sd16384)
        begin
            ang_fold = ang_ext - 17'sd32768;
            fold_neg = 1'b1;
        end
        else if (ang_ext < -17'sd16384)
        begin
            ang_fold = ang_ext + 17'sd32768;
            fold_neg = 1'b1;
        end
    end

    always_comb
    begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        atan_val = $signed({{(CS_W-ATAN_W){1'b0}}, atan_lut(iter_reg)});
        if (!z_reg[CS_W-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
        last_iter = (iter_reg == ITER_W'(CORDIC_ITERS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                neg_reg  <= fold_neg;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (last_iter)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= CS_W'(CORDIC_GAIN_INV);
            y_reg <= '0;
            z_reg <= CS_W'(ang_fold);
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (last_iter)
            begin
                cos_reg <= neg_reg ? -x_next : x_next;
                sin_reg <= neg_reg ? -y_next : y_next;
            end
        end
    end

    assign res.done    = done_reg;
    assign res.cos_val = cos_reg;
    assign res.sin_val = sin_reg;

endmodule

// ----- src/lezic_checker.sv -----
// Port-level checks for the lidar ellipse zone intrusion counter, bound to its top level.
module lezic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import lezic_pkg::*;

    // A waiting result beat must hold its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The unit works on one sample at a time, so it is busy right after a beat is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // The count never passes its saturation limit and the padding stays clear.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:1] <= 12'(COUNT_CAP)) && (m_axis_tdata[15:13] == 3'b000))
        else $error("result count out of range");

    // A fresh result never appears in the cycle straight after a sample is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared without processing time");

endmodule

bind lidar_ellipse_zone_intrusion_count_unit lezic_checker u_lezic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/zone_verdict_checker.sv -----
// Checker that predicts each scan verdict of the ellipse zone counter and compares the output beats.
`timescale 1ns / 1ps

module zone_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] range_mm
    input  logic                            s_axis_tuser,  // [0] no_return
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [15:0]                     m_axis_tdata,  // [0] stop, [12:1] count
    input  logic                            cfg_we,
    input  logic [lezic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lezic_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              verdicts_waiting,
    output int                              verdicts_checked
);

    import lezic_pkg::*;

    localparam logic [11:0] THRESHOLD_DEFAULT  = 12'd10;
    localparam logic [15:0] ANGLE_INC_DEFAULT  = 16'd182;
    localparam logic [11:0] RADIUS_X_DEFAULT   = 12'd270;
    localparam logic [11:0] RADIUS_Y_DEFAULT   = 12'd170;
    localparam logic [12:0] OFFSET_X_DEFAULT   = 13'd100;
    localparam logic [12:0] OFFSET_Y_DEFAULT   = 13'd0;
    localparam logic [15:0] HALF_TURN          = 16'h8000;
    localparam int          QUARTER_TURN       = 16384;
    localparam int          ROUND_HALF         = 16384;

    localparam int ROTATION_ANGLES [CORDIC_ITERS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    typedef struct {
        logic        stop;
        logic [11:0] count;
    } scan_verdict_t;

    scan_verdict_t pending_verdicts [$];
    scan_verdict_t want_v;
    scan_verdict_t new_v;

    logic [11:0] threshold_q;
    logic [15:0] angle_inc_q;
    logic [11:0] radius_x_q;
    logic [11:0] radius_y_q;
    logic [12:0] offset_x_q;
    logic [12:0] offset_y_q;

    logic [15:0] bearing;
    logic [11:0] hits;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic bit point_in_zone(input logic [15:0] range_mm, input logic [15:0] ang);
        int a;
        int cx;
        int cy;
        int rem;
        int xs;
        int ys;
        int i;
        bit flip;
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint unsigned udx;
        longint unsigned udy;
        longint unsigned rx2;
        longint unsigned ry2;
        longint unsigned lhs;
        longint unsigned rhs;
        a = int'($signed(ang));
        flip = 1'b0;
        if (a > QUARTER_TURN)
        begin
            a = a - 2 * QUARTER_TURN;
            flip = 1'b1;
        end
        else if (a < -QUARTER_TURN)
        begin
            a = a + 2 * QUARTER_TURN;
            flip = 1'b1;
        end
        cx = CORDIC_GAIN_INV;
        cy = 0;
        rem = a;
        for (i = 0; i < CORDIC_ITERS; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (rem >= 0)
            begin
                cx = cx - ys;
                cy = cy + xs;
                rem = rem - ROTATION_ANGLES[i];
            end
            else
            begin
                cx = cx + ys;
                cy = cy - xs;
                rem = rem + ROTATION_ANGLES[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        px = (longint'(range_mm) * longint'(cx) + ROUND_HALF) >>> 15;
        py = (longint'(range_mm) * longint'(cy) + ROUND_HALF) >>> 15;
        dx = px - longint'($signed(offset_x_q));
        dy = py - longint'($signed(offset_y_q));
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        udx = dx;
        udy = dy;
        rx2 = longint'(radius_x_q) * longint'(radius_x_q);
        ry2 = longint'(radius_y_q) * longint'(radius_y_q);
        lhs = udx * udx * ry2 + udy * udy * rx2;
        rhs = rx2 * ry2;
        return lhs <= rhs;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_q = THRESHOLD_DEFAULT;
            angle_inc_q = ANGLE_INC_DEFAULT;
            radius_x_q = RADIUS_X_DEFAULT;
            radius_y_q = RADIUS_Y_DEFAULT;
            offset_x_q = OFFSET_X_DEFAULT;
            offset_y_q = OFFSET_Y_DEFAULT;
            bearing = HALF_TURN;
            hits = '0;
            pending_verdicts.delete();
            mismatches = 0;
            verdicts_waiting = 0;
            verdicts_checked = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch("verdict beat with none waiting", m_axis_tdata, -1);
                else
                begin
                    want_v = pending_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want_v.stop)
                        report_mismatch("stop flag", m_axis_tdata[0], want_v.stop);
                    if (m_axis_tdata[12:1] !== want_v.count)
                        report_mismatch("intrusion count", m_axis_tdata[12:1], want_v.count);
                    verdicts_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (!s_axis_tuser && point_in_zone(s_axis_tdata, bearing))
                begin
                    if (hits < COUNT_CAP)
                        hits = hits + 12'd1;
                end
                bearing = bearing - angle_inc_q;
                if (s_axis_tlast)
                begin
                    new_v.stop = (hits > threshold_q);
                    new_v.count = hits;
                    pending_verdicts.push_back(new_v);
                    bearing = HALF_TURN;
                    hits = '0;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  threshold_q = cfg_data[11:0];
                    REG_ANGLE_STEP: angle_inc_q = cfg_data[15:0];
                    REG_RADIUS_X:   radius_x_q = cfg_data[11:0];
                    REG_RADIUS_Y:   radius_y_q = cfg_data[11:0];
                    REG_OFFSET_X:   offset_x_q = cfg_data[12:0];
                    REG_OFFSET_Y:   offset_y_q = cfg_data[12:0];
                    default:        ;
                endcase
            end
            verdicts_waiting = pending_verdicts.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top: clock, reset, sample and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb;

    import lezic_pkg::*;

    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          RANDOM_PHASES = 9;
    localparam int          PHASE_BEATS   = 100;
    localparam logic [2:0]  REG_SPARE_A   = 3'd6;
    localparam logic [2:0]  REG_SPARE_B   = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int verdicts_waiting;
    int verdicts_checked;

    int cycles = 0;
    int beats_sent = 0;
    int scans_sent = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int stall_left = 0;
    int phase_beats;
    bit idle_on = 1'b1;
    bit idling = 1'b1;

    always #4 clk = ~clk;

    lidar_ellipse_zone_intrusion_count_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    zone_verdict_checker verdict_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .verdicts_waiting (verdicts_waiting),
        .verdicts_checked (verdicts_checked)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // While idling is on, the receiver drops ready at random in bursts of random length.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_beat(input logic [15:0] range_mm, input logic no_ret, input logic last);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= range_mm;
        s_axis_tuser <= no_ret;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        phase_beats++;
        if (last)
            scans_sent++;
        @(negedge clk);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (verdicts_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [15:0] inc,
                                  input logic [15:0] rx, input logic [15:0] ry,
                                  input logic [15:0] ox, input logic [15:0] oy);
        settle_block();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_ANGLE_STEP, inc);
        write_reg(REG_RADIUS_X, rx);
        write_reg(REG_RADIUS_Y, ry);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_SPARE_A, 16'($urandom));
        else
            write_reg(REG_SPARE_B, 16'($urandom));
        settings_used++;
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 300));
            1:       return 16'($urandom_range(0, 600));
            2:       return 16'($urandom_range(0, 4500));
            3:       return 16'($urandom);
            4:       return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
            default: return 16'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        return 16'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    task automatic run_scan(input int len);
        int i;
        idling = idle_on && ($urandom_range(0, 2) != 0);
        for (i = 0; i < len; i++)
            send_beat(pick_range(), $urandom_range(0, 6) == 0, i == len - 1);
    endtask

    task automatic random_settings(input int phase);
        case (phase)
            0: apply_settings(16'd0, 16'd0, 16'd1, 16'd1, 16'(-4096), 16'(-4096));
            1: apply_settings(16'd2048, 16'hFFFF, 16'd4095, 16'd4095, 16'd4095, 16'd4095);
            2: apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            default:
            begin
                apply_settings(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2048))
                                                           : 16'($urandom_range(0, 12)),
                               ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 4096)),
                               16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                               pick_offset(), pick_offset());
            end
        endcase
    endtask

    initial
    begin
        int p;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Register defaults: a point at the sensor, skipped and distant returns, a
        // one-beat scan with no return and a one-beat scan that counts its last beat.
        send_beat(16'd0, 1'b0, 1'b0);
        send_beat(16'hFFFF, 1'b1, 1'b0);
        send_beat(16'hFFFF, 1'b0, 1'b0);
        send_beat(16'd170, 1'b0, 1'b0);
        send_beat(16'd0, 1'b0, 1'b1);
        send_beat(16'd0, 1'b1, 1'b1);
        send_beat(16'd0, 1'b0, 1'b1);

        // Quarter-turn steps visit both folded and unfolded angles and wrap the bearing.
        apply_settings(16'd0, 16'd16384, 16'd270, 16'd170, 16'd100, 16'd0);
        send_beat(16'd150, 1'b0, 1'b0);
        send_beat(16'd100, 1'b0, 1'b0);
        send_beat(16'd370, 1'b0, 1'b0);
        send_beat(16'hFFFF, 1'b0, 1'b0);
        send_beat(16'd0, 1'b0, 1'b0);
        send_beat(16'd369, 1'b0, 1'b1);

        // A radius written as zero collapses the ellipse.
        apply_settings(16'd2048, 16'd16384, 16'h1000, 16'd170, 16'd0, 16'd0);
        send_beat(16'd500, 1'b0, 1'b0);
        send_beat(16'd500, 1'b0, 1'b0);
        send_beat(16'd500, 1'b0, 1'b0);
        send_beat(16'd500, 1'b0, 1'b1);

        // With no angle step every beat looks the same way.
        apply_settings(16'd1, 16'd0, 16'd270, 16'd170, 16'd100, 16'd0);
        send_beat(16'd200, 1'b0, 1'b0);
        send_beat(16'd200, 1'b1, 1'b0);
        send_beat(16'd200, 1'b0, 1'b1);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            random_settings(p);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
                run_scan($urandom_range(1, 30));
        end

        idle_on = 1'b0;
        idling = 1'b0;
        random_settings(RANDOM_PHASES);
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS)
            run_scan($urandom_range(1, 30));

        settle_block();
        $display("Sent %0d beats in %0d scans over %0d register settings (%0d writes).",
                 beats_sent, scans_sent, settings_used, reg_writes);
        $display("Compared %0d scan verdicts, %0d mismatches.", verdicts_checked, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/lezic_pkg.sv
src/lezic_mul.sv
src/lezic_cordic.sv
src/lidar_ellipse_zone_intrusion_count_unit.sv
src/lezic_checker.sv
verif/zone_verdict_checker.sv
verif/tb.sv
